[hdl/multichannel_rx_chunk_fifo_core_macros.svh]
// assertion macros shared by the receive chunk fifo modules
`ifndef MULTICHANNEL_RX_CHUNK_FIFO_CORE_MACROS_SVH
`define MULTICHANNEL_RX_CHUNK_FIFO_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define MRCF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MRCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mrcf_pkg.sv]
// shared types and constants of the receive chunk fifo
package mrcf_pkg;

    localparam int CHANNELS_DEF   = 4;
    localparam int FIFO_DEPTH_DEF = 128;

    // byte lanes of the banked store, one bank per chunk byte
    localparam int LANES  = 3;
    localparam int LANE_W = 2;

    // request kinds carried on tuser
    localparam logic REQ_CHUNK = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 88;

    typedef logic [LANE_W-1:0] t_lane;

    typedef struct packed {
        logic       req_type;
        logic [1:0] chan_sel;
        logic       packet_ok;
        logic [1:0] chunk_count;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
    } t_req;

    typedef struct packed {
        logic        read_valid;
        t_lane       rd_lane;
        logic [1:0]  stored_bytes;
        logic [1:0]  dropped_bytes;
        logic [7:0]  fill_level;
        logic [31:0] recv_total;
        logic [31:0] drop_total;
    } t_res;

endpackage

[hdl/multichannel_rx_chunk_fifo_core.sv]
// top level of the multichannel receive chunk fifo
// Per-channel receive byte FIFOs. A chunk transaction (tuser = 0) offers up to
// three bytes to one channel; as many as fit are stored in order and the rest
// are dropped, with both amounts added to wrapping 32-bit per-channel totals.
// A chunk with packet_ok low or a count of zero changes nothing. A read
// transaction (tuser = 1) pops one byte, or returns read_valid low when the
// channel is empty. Every transaction yields exactly one result carrying the
// channel's fill level and totals after the step; a channel number at or above
// CHANNELS yields an all-zero result. Throughput is one transaction per clock
// while m_axis_tready does not stall the output: the request goes into an input
// register, the per-channel update runs as combinational logic into the result
// register, and the result is driven onto the output from that register. The
// byte store is three byte-wide RAM banks with a registered read port, one bank
// per chunk byte, which lets all bytes of a chunk be written into the banks
// together. The store needs no clearing after reset: a byte is only ever read
// after it was written.
module multichannel_rx_chunk_fifo_core #(
    parameter int CHANNELS   = mrcf_pkg::CHANNELS_DEF,
    parameter int FIFO_DEPTH = mrcf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side: request transactions
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // chan_sel[1:0], packet_ok[2], chunk_count[4:3], byte_a[12:5],
    // byte_b[20:13], byte_c[28:21], zero pad [31:29]
    input  logic [mrcf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // req_type[0]
    input  logic                               s_axis_tuser,
    // master side: result transactions
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // read_data[7:0], read_valid[8], stored_bytes[10:9], dropped_bytes[12:11],
    // fill_level[20:13], recv_total[52:21], drop_total[84:53], zero pad [87:85]
    output logic [mrcf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import mrcf_pkg::*;

    localparam int ROWS   = (FIFO_DEPTH + LANES - 1) / LANES;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W = CH_W + ROW_W;
    localparam int BANK_D = 1 << ADDR_W;

    // input register
    logic r_in_valid;
    t_req r_req;
    // result register
    logic r_out_valid;
    t_res r_res;

    logic              advance;
    t_res              res;
    logic              bank_we    [LANES];
    logic [ADDR_W-1:0] bank_waddr [LANES];
    logic [7:0]        bank_wdata [LANES];
    logic [ADDR_W-1:0] bank_raddr;
    logic [7:0]        bank_q     [LANES];
    logic [7:0]        read_data;

    // the request in the input register moves on whenever the result slot is free
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_req.req_type    <= s_axis_tuser;
            r_req.chan_sel    <= s_axis_tdata[1:0];
            r_req.packet_ok   <= s_axis_tdata[2];
            r_req.chunk_count <= s_axis_tdata[4:3];
            r_req.byte_a      <= s_axis_tdata[12:5];
            r_req.byte_b      <= s_axis_tdata[20:13];
            r_req.byte_c      <= s_axis_tdata[28:21];
        end
        if (advance) begin
            r_res <= res;
        end
    end

    mrcf_chan_ctrl #(
        .CHANNELS   (CHANNELS),
        .FIFO_DEPTH (FIFO_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_chan_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (advance),
        .i_req    (r_req),
        .o_res    (res),
        .o_we     (bank_we),
        .o_waddr  (bank_waddr),
        .o_wdata  (bank_wdata),
        .o_raddr  (bank_raddr)
    );

    // byte banks; the read data register holds while the result is stalled
    for (genvar b = 0; b < LANES; b++) begin : g_bank
        mrcf_ram #(
            .WIDTH (8),
            .DEPTH (BANK_D)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (bank_we[b]),
            .i_waddr (bank_waddr[b]),
            .i_wdata (bank_wdata[b]),
            .i_re    (advance),
            .i_raddr (bank_raddr),
            .o_rdata (bank_q[b])
        );
    end

    always_comb begin
        read_data = 8'd0;
        if (r_res.read_valid) begin
            case (r_res.rd_lane)
                2'd0:    read_data = bank_q[0];
                2'd1:    read_data = bank_q[1];
                default: read_data = bank_q[2];
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0,
                            r_res.drop_total,
                            r_res.recv_total,
                            r_res.fill_level,
                            r_res.dropped_bytes,
                            r_res.stored_bytes,
                            r_res.read_valid,
                            read_data};

`include "multichannel_rx_chunk_fifo_core_macros.svh"

    `MRCF_ASSERT_NOW(a_stall_blocks_input, r_in_valid && r_out_valid && !m_axis_tready, !s_axis_tready, "input taken while both stages are full and stalled")
    `MRCF_ASSERT_NEXT(a_advance_fills_output, advance, r_out_valid, "advanced transaction lost before the result register")
    `MRCF_ASSERT_NOW(a_single_bank_on_read, r_req.req_type == REQ_READ, !bank_we[0] && !bank_we[1] && !bank_we[2], "bank written by a read transaction")

endmodule

[hdl/mrcf_ram.sv]
// generic single-write, registered-read ram
module mrcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/mrcf_chan_ctrl.sv]
// per-channel pointers, fill counts and totals, and bank write/read control
module mrcf_chan_ctrl #(
    parameter int CHANNELS   = mrcf_pkg::CHANNELS_DEF,
    parameter int FIFO_DEPTH = mrcf_pkg::FIFO_DEPTH_DEF,
    parameter int ADDR_W     = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_commit,
    input  mrcf_pkg::t_req      i_req,
    output mrcf_pkg::t_res      o_res,
    output logic                o_we    [mrcf_pkg::LANES],
    output logic [ADDR_W-1:0]   o_waddr [mrcf_pkg::LANES],
    output logic [7:0]          o_wdata [mrcf_pkg::LANES],
    output logic [ADDR_W-1:0]   o_raddr
);
    import mrcf_pkg::*;

    localparam int ROWS   = (FIFO_DEPTH + LANES - 1) / LANES;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

    logic [ROW_W-1:0]  r_wrow  [CHANNELS];
    t_lane             r_wlane [CHANNELS];
    logic [ROW_W-1:0]  r_rrow  [CHANNELS];
    t_lane             r_rlane [CHANNELS];
    logic [FILL_W-1:0] r_fill  [CHANNELS];
    logic [31:0]       r_acc   [CHANNELS];
    logic [31:0]       r_drop  [CHANNELS];

    logic [ROW_W-1:0]  n_wrow;
    t_lane             n_wlane;
    logic [ROW_W-1:0]  n_rrow;
    t_lane             n_rlane;
    logic [FILL_W-1:0] n_fill;
    logic [31:0]       n_acc;
    logic [31:0]       n_drop;

    logic [CH_W+1:0]   ch_ext;
    logic [CH_W-1:0]   ch;
    logic              in_range;
    logic              is_chunk;
    logic              is_read;
    logic              do_read;
    logic [ROW_W-1:0]  cur_wrow;
    logic [ROW_W-1:0]  wrow_next;
    t_lane             cur_wlane;
    logic [ROW_W-1:0]  cur_rrow;
    t_lane             cur_rlane;
    logic [FILL_W-1:0] cur_fill;
    logic [FILL_W-1:0] room;
    logic [1:0]        stored;
    logic [1:0]        dropped;
    logic [2:0]        lane_sum;
    logic [FILL_W+7:0] fill_ext;
    logic [2:0]        stored_sum;

    assign ch_ext   = {{CH_W{1'b0}}, i_req.chan_sel};
    assign ch       = ch_ext[CH_W-1:0];
    assign in_range = ch_ext < (CH_W + 2)'(CHANNELS);
    assign is_chunk = in_range && (i_req.req_type == REQ_CHUNK) && i_req.packet_ok
                      && (i_req.chunk_count != 2'd0);
    assign is_read  = in_range && (i_req.req_type == REQ_READ);

    assign cur_wrow  = in_range ? r_wrow[ch]  : '0;
    assign cur_wlane = in_range ? r_wlane[ch] : '0;
    assign cur_rrow  = in_range ? r_rrow[ch]  : '0;
    assign cur_rlane = in_range ? r_rlane[ch] : '0;
    assign cur_fill  = in_range ? r_fill[ch]  : '0;

    assign wrow_next = (cur_wrow == ROW_W'(ROWS - 1)) ? '0 : cur_wrow + 1'b1;

    // free room caps the chunk, later bytes are the ones dropped
    assign room    = FILL_W'(FIFO_DEPTH) - cur_fill;
    assign stored  = !is_chunk ? 2'd0 :
                     (room < {{(FILL_W-2){1'b0}}, i_req.chunk_count}) ? room[1:0] :
                     i_req.chunk_count;
    assign dropped = is_chunk ? i_req.chunk_count - stored : 2'd0;
    assign do_read = is_read && (cur_fill != '0);

    always_comb begin
        n_wrow   = cur_wrow;
        n_wlane  = cur_wlane;
        n_rrow   = cur_rrow;
        n_rlane  = cur_rlane;
        n_fill   = cur_fill;
        n_acc    = in_range ? r_acc[ch]  : '0;
        n_drop   = in_range ? r_drop[ch] : '0;
        lane_sum = {1'b0, cur_wlane} + {1'b0, stored};
        if (is_chunk) begin
            if (lane_sum >= 3'(LANES)) begin
                n_wlane = LANE_W'(lane_sum - 3'(LANES));
                n_wrow  = wrow_next;
            end else begin
                n_wlane = LANE_W'(lane_sum);
            end
            n_fill = cur_fill + FILL_W'(stored);
            n_acc  = n_acc + 32'(stored);
            n_drop = n_drop + 32'(dropped);
        end
        if (do_read) begin
            if (cur_rlane == LANE_W'(LANES - 1)) begin
                n_rlane = '0;
                n_rrow  = (cur_rrow == ROW_W'(ROWS - 1)) ? '0 : cur_rrow + 1'b1;
            end else begin
                n_rlane = cur_rlane + 1'b1;
            end
            n_fill = cur_fill - 1'b1;
        end
    end

    // bank b takes chunk byte (b - write lane) mod lanes, one row on when it wrapped
    always_comb begin
        logic [2:0] diff;
        logic [2:0] off;
        for (int b = 0; b < LANES; b++) begin
            diff = 3'(b) + 3'(LANES) - {1'b0, cur_wlane};
            off  = (diff >= 3'(LANES)) ? diff - 3'(LANES) : diff;
            o_we[b]    = i_commit && (off < {1'b0, stored});
            o_waddr[b] = {ch, (3'(b) < {1'b0, cur_wlane}) ? wrow_next : cur_wrow};
            case (off)
                3'd0:    o_wdata[b] = i_req.byte_a;
                3'd1:    o_wdata[b] = i_req.byte_b;
                default: o_wdata[b] = i_req.byte_c;
            endcase
        end
    end

    assign o_raddr  = {ch, cur_rrow};
    assign fill_ext = {8'd0, n_fill};

    always_comb begin
        o_res               = '0;
        o_res.read_valid    = do_read;
        o_res.rd_lane       = cur_rlane;
        o_res.stored_bytes  = stored;
        o_res.dropped_bytes = dropped;
        if (in_range) begin
            o_res.fill_level = fill_ext[7:0];
            o_res.recv_total = n_acc;
            o_res.drop_total = n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_wrow[c]  <= '0;
                r_wlane[c] <= '0;
                r_rrow[c]  <= '0;
                r_rlane[c] <= '0;
                r_fill[c]  <= '0;
                r_acc[c]   <= '0;
                r_drop[c]  <= '0;
            end
        end else if (i_commit && in_range) begin
            r_wrow[ch]  <= n_wrow;
            r_wlane[ch] <= n_wlane;
            r_rrow[ch]  <= n_rrow;
            r_rlane[ch] <= n_rlane;
            r_fill[ch]  <= n_fill;
            r_acc[ch]   <= n_acc;
            r_drop[ch]  <= n_drop;
        end
    end

    assign stored_sum = {1'b0, stored} + {1'b0, dropped};

`include "multichannel_rx_chunk_fifo_core_macros.svh"

    `MRCF_ASSERT_NOW(a_chunk_split, is_chunk, stored_sum == {1'b0, i_req.chunk_count}, "chunk bytes not fully accounted")
    `MRCF_ASSERT_NOW(a_fill_bound, in_range, cur_fill <= FILL_W'(FIFO_DEPTH), "fill count beyond depth")
    `MRCF_ASSERT_NOW(a_pop_nonempty, o_res.read_valid, is_read && (cur_fill != '0), "pop from empty or non-read")
    `MRCF_ASSERT_NOW(a_no_write_on_read, is_read, stored == 2'd0, "read request writes the store")

endmodule
